### hdl/cpb_pkg.sv
// Shared types, widths and constant tables for the cartesian-to-polar bearing core.
`timescale 1ns / 1ps
`default_nettype none

package cpb_pkg;

   localparam int COORD_BITS = 24;
   localparam int ANGLE_BITS = 16;
   localparam int DIST_BITS  = 24;
   localparam int MODE_BITS  = 3;
   localparam int TURN_BITS  = 32;

   localparam int ROTATION_STEPS_DEFAULT = 18;

   // The larger magnitude is normalized into [2^58, 2^59) before rotation.
   localparam int NORM_BITS   = 59;
   localparam int NORM_STAGES = 6;
   localparam int CX_BITS     = 62;

   localparam int ROOT_BITS = COORD_BITS;
   localparam int REM_BITS  = COORD_BITS + 1;
   localparam int RAD_BITS  = 2 * COORD_BITS;

   localparam logic [TURN_BITS-1:0] ANGLE_ROUND =
      TURN_BITS'(1) << (TURN_BITS - 1 - ANGLE_BITS);

   localparam logic [TURN_BITS-1:0] ATAN_TURNS [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   localparam logic [TURN_BITS-1:0] ORIGIN_ANGLE [8] = '{
      32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000,
      32'h4000_0000, 32'h4000_0000, 32'hC000_0000, 32'hC000_0000
   };

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_coord;
      logic signed [COORD_BITS-1:0] y_coord;
   } req_type;

   typedef struct packed {
      logic [DIST_BITS-1:0]  distance;
      logic [ANGLE_BITS-1:0] angle;
   } rsp_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic                 origin;
      logic                 bzero;
      logic                 neg;
      logic [1:0]           quarter;
   } flag_type;

endpackage

`default_nettype wire

### hdl/cartesian_to_polar_bearing_core.sv
// Top level of the cartesian-to-polar bearing core: front end, cell chains and result stage.
//
//   channel   ports                          direction   handshake
//   request   start, busy, req_data          in          start high while busy low
//   response  rsp_valid, rsp_data            out         one-cycle strobe, no stall
//   control   csr_wr_en, csr_wr_data         in          write on enable, no wait
//
// One item is taken every cycle; busy is high only while reset is asserted.
// The path from the accepting edge to the result register is set by the longer of the
// vectoring chain and the square-root chain; the shorter is padded by a delay line.
// Reset is synchronous and clears the bearing mode and all valid bits.
// The response side cannot stall, so nothing inside ever holds.
`timescale 1ns / 1ps
`default_nettype none

module cartesian_to_polar_bearing_core
   import cpb_pkg::*;
#(
   parameter int ROTATION_STEPS = ROTATION_STEPS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [MODE_BITS-1:0] csr_wr_data
);

   localparam int ANG_END  = 1 + NORM_STAGES + ROTATION_STEPS;
   localparam int DIST_END = 2 + ROOT_BITS;
   localparam int LAST     = (ANG_END > DIST_END) ? ANG_END : DIST_END;
   localparam int LATENCY  = LAST + 2;

   function automatic logic [COORD_BITS-1:0] mag(input logic signed [COORD_BITS:0] val);
      logic signed [COORD_BITS:0] pos;
      pos = val[COORD_BITS] ? -val : val;
      return pos[COORD_BITS-1:0];
   endfunction

   logic                 accept;
   logic [MODE_BITS-1:0] mode_ff, mode_in;
   req_type              req_ff;
   logic [MODE_BITS-1:0] req_mode_ff;
   logic                 valid_ff [LAST+1];
   flag_type             flag_ff [LAST];
   flag_type             flag_in;

   // Front end
   logic signed [COORD_BITS:0] xs, ys, u, v;
   logic [COORD_BITS-1:0]      mu, mv, ax, ay;
   logic                       swapped;
   logic [1:0]                 q_half;
   logic [COORD_BITS-1:0]      a_ff, a_in, b_ff, b_in;
   logic [RAD_BITS-1:0]        sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [RAD_BITS-1:0]        sum_ff, sum_in;

   // Chains
   logic [NORM_BITS-1:0]      a_w [NORM_STAGES+1];
   logic [NORM_BITS-1:0]      b_w [NORM_STAGES+1];
   logic signed [CX_BITS-1:0] cx_w [ROTATION_STEPS+1];
   logic signed [CX_BITS-1:0] cy_w [ROTATION_STEPS+1];
   logic [TURN_BITS-1:0]      z_w [ROTATION_STEPS+1];
   logic [RAD_BITS-1:0]       rad_w [ROOT_BITS+1];
   logic [REM_BITS-1:0]       rem_w [ROOT_BITS+1];
   logic [ROOT_BITS-1:0]      root_w [ROOT_BITS+1];

   // Chain ends and result
   flag_type             ang_flag;
   logic [TURN_BITS-1:0] z_base, z_signed, z_fold, z_dly;
   logic [ROOT_BITS-1:0] dist_end, dist_dly;
   flag_type             end_flag;
   logic [TURN_BITS-1:0] ang_sel, ang_rnd;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // Configuration register
   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Entry registers
   always_ff @(posedge clock) begin
      req_ff      <= req_data;
      req_mode_ff <= mode_ff;
   end

   // Map the point onto the selected reference axis and fold it into the first octant.
   always_comb begin
      xs = {req_ff.x_coord[COORD_BITS-1], req_ff.x_coord};
      ys = {req_ff.y_coord[COORD_BITS-1], req_ff.y_coord};
      if (!req_mode_ff[2]) begin
         u = req_mode_ff[1] ? -ys : ys;
         v = req_mode_ff[0] ? -xs : xs;
      end else begin
         u = req_mode_ff[0] ? -xs : xs;
         v = req_mode_ff[1] ? -ys : ys;
      end
      mu      = mag(u);
      mv      = mag(v);
      ax      = mag(xs);
      ay      = mag(ys);
      swapped = (mv > mu);
      a_in    = swapped ? mv : mu;
      b_in    = swapped ? mu : mv;
      sqx_in  = RAD_BITS'(ax) * RAD_BITS'(ax);
      sqy_in  = RAD_BITS'(ay) * RAD_BITS'(ay);

      // The quadrant unfolding is an offset in quarter turns plus a sign on the angle.
      q_half          = u[COORD_BITS] ? (2'd2 - {1'b0, swapped}) : {1'b0, swapped};
      flag_in.quarter = v[COORD_BITS] ? (2'd0 - q_half) : q_half;
      flag_in.neg     = swapped ^ u[COORD_BITS] ^ v[COORD_BITS];
      flag_in.bzero   = (b_in == '0);
      flag_in.origin  = (req_ff.x_coord == '0) && (req_ff.y_coord == '0);
      flag_in.mode    = req_mode_ff;
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      sum_ff <= sum_in;
   end

   assign sum_in = sqx_ff + sqy_ff;

   // Valid and side flags travel alongside the chains.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= accept;
         for (int k = 1; k <= LAST; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      flag_ff[0] <= flag_in;
      for (int k = 1; k < LAST; k++) begin
         flag_ff[k] <= flag_ff[k-1];
      end
   end

   // Normalizing cells
   assign a_w[0] = NORM_BITS'(a_ff);
   assign b_w[0] = NORM_BITS'(b_ff);

   generate
      for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
         cpb_norm_cell #(
            .SHIFT(1 << (NORM_STAGES - 1 - j))
         ) u_norm (
            .clock(clock),
            .up_a (a_w[j]),
            .up_b (b_w[j]),
            .dn_a (a_w[j+1]),
            .dn_b (b_w[j+1])
         );
      end
   endgenerate

   // Vectoring cells
   assign cx_w[0] = signed'(CX_BITS'(a_w[NORM_STAGES]));
   assign cy_w[0] = signed'(CX_BITS'(b_w[NORM_STAGES]));
   assign z_w[0]  = '0;

   generate
      for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_rot
         cpb_rot_cell #(
            .STEP(i)
         ) u_rot (
            .clock(clock),
            .up_cx(cx_w[i]),
            .up_cy(cy_w[i]),
            .up_z (z_w[i]),
            .dn_cx(cx_w[i+1]),
            .dn_cy(cy_w[i+1]),
            .dn_z (z_w[i+1])
         );
      end
   endgenerate

   // Square-root cells
   assign rad_w[0]  = sum_ff;
   assign rem_w[0]  = '0;
   assign root_w[0] = '0;

   generate
      for (genvar r = 0; r < ROOT_BITS; r++) begin : g_sqrt
         cpb_sqrt_cell u_sqrt (
            .clock  (clock),
            .up_rad (rad_w[r]),
            .up_rem (rem_w[r]),
            .up_root(root_w[r]),
            .dn_rad (rad_w[r+1]),
            .dn_rem (rem_w[r+1]),
            .dn_root(root_w[r+1])
         );
      end
   endgenerate

   // Unfold the first-octant angle back to the full turn.
   always_comb begin
      ang_flag = flag_ff[ANG_END-1];
      z_base   = ang_flag.bzero ? '0 : z_w[ROTATION_STEPS];
      z_signed = ang_flag.neg ? (TURN_BITS'(0) - z_base) : z_base;
      z_fold   = {ang_flag.quarter, (TURN_BITS-2)'(0)} + z_signed;
   end

   // Round the root to nearest: bump it when the remainder exceeds the root.
   assign dist_end = root_w[ROOT_BITS]
                   + ROOT_BITS'(rem_w[ROOT_BITS] > REM_BITS'(root_w[ROOT_BITS]));

   cpb_delay #(
      .WIDTH(TURN_BITS),
      .DEPTH(LAST - ANG_END)
   ) u_ang_delay (
      .clock  (clock),
      .up_data(z_fold),
      .dn_data(z_dly)
   );

   cpb_delay #(
      .WIDTH(ROOT_BITS),
      .DEPTH(LAST - DIST_END)
   ) u_dist_delay (
      .clock  (clock),
      .up_data(dist_end),
      .dn_data(dist_dly)
   );

   // Result stage
   always_comb begin
      end_flag        = flag_ff[LAST-1];
      ang_sel         = end_flag.origin ? ORIGIN_ANGLE[end_flag.mode] : z_dly;
      ang_rnd         = ang_sel + ANGLE_ROUND;
      rsp_in.distance = dist_dly[DIST_BITS-1:0];
      rsp_in.angle    = ang_rnd[TURN_BITS-1 -: ANGLE_BITS];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[LAST];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result only ever follows an accepted item by the fixed latency.
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching accepted item");

   // The origin always reports a zero distance.
   a_origin_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(start && !busy && req_data.x_coord == '0 &&
                         req_data.y_coord == '0, LATENCY)
      |-> rsp_data.distance == '0)
      else $error("origin item gave a nonzero distance");

   // The final remainder is at most twice the root.
   a_sqrt_remainder: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DIST_END] |-> rem_w[ROOT_BITS] <= {root_w[ROOT_BITS], 1'b0})
      else $error("square-root remainder out of range");

   // Away from the origin the normalized major magnitude has its top bit set.
   a_norm_top: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1+NORM_STAGES] && !flag_ff[NORM_STAGES].origin
      |-> a_w[NORM_STAGES][NORM_BITS-1])
      else $error("normalizer left the major magnitude unnormalized");

endmodule

`default_nettype wire

### hdl/cpb_norm_cell.sv
// One normalizing cell: shifts both magnitudes left by a fixed amount when room allows.
`timescale 1ns / 1ps
`default_nettype none

module cpb_norm_cell
   import cpb_pkg::*;
#(
   parameter int SHIFT = 1
) (
   input  logic                 clock,
   input  logic [NORM_BITS-1:0] up_a,
   input  logic [NORM_BITS-1:0] up_b,
   output logic [NORM_BITS-1:0] dn_a,
   output logic [NORM_BITS-1:0] dn_b
);

   logic                 take;
   logic [NORM_BITS-1:0] a_ff, a_in;
   logic [NORM_BITS-1:0] b_ff, b_in;

   assign take = (up_a[NORM_BITS-1 -: SHIFT] == '0);

   always_comb begin
      a_in = take ? (up_a << SHIFT) : up_a;
      b_in = take ? (up_b << SHIFT) : up_b;
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign dn_a = a_ff;
   assign dn_b = b_ff;

endmodule

`default_nettype wire

### hdl/cpb_rot_cell.sv
// One vectoring cell: a single fixed-shift rotation step with its angle update.
`timescale 1ns / 1ps
`default_nettype none

module cpb_rot_cell
   import cpb_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic                       clock,
   input  logic signed [CX_BITS-1:0]  up_cx,
   input  logic signed [CX_BITS-1:0]  up_cy,
   input  logic [TURN_BITS-1:0]       up_z,
   output logic signed [CX_BITS-1:0]  dn_cx,
   output logic signed [CX_BITS-1:0]  dn_cy,
   output logic [TURN_BITS-1:0]       dn_z
);

   logic signed [CX_BITS-1:0] dx, dy;
   logic signed [CX_BITS-1:0] cx_ff, cx_in;
   logic signed [CX_BITS-1:0] cy_ff, cy_in;
   logic [TURN_BITS-1:0]      z_ff, z_in;

   // Arithmetic shifts round toward minus infinity, as required.
   assign dx = up_cy >>> STEP;
   assign dy = up_cx >>> STEP;

   always_comb begin
      if (!up_cy[CX_BITS-1]) begin
         cx_in = up_cx + dx;
         cy_in = up_cy - dy;
         z_in  = up_z + ATAN_TURNS[STEP];
      end else begin
         cx_in = up_cx - dx;
         cy_in = up_cy + dy;
         z_in  = up_z - ATAN_TURNS[STEP];
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      z_ff  <= z_in;
   end

   assign dn_cx = cx_ff;
   assign dn_cy = cy_ff;
   assign dn_z  = z_ff;

endmodule

`default_nettype wire

### hdl/cpb_sqrt_cell.sv
// One square-root cell: resolves one bit of the root from the next radicand bit pair.
`timescale 1ns / 1ps
`default_nettype none

module cpb_sqrt_cell
   import cpb_pkg::*;
(
   input  logic                 clock,
   input  logic [RAD_BITS-1:0]  up_rad,
   input  logic [REM_BITS-1:0]  up_rem,
   input  logic [ROOT_BITS-1:0] up_root,
   output logic [RAD_BITS-1:0]  dn_rad,
   output logic [REM_BITS-1:0]  dn_rem,
   output logic [ROOT_BITS-1:0] dn_root
);

   logic [REM_BITS+1:0]  cur, trial, diff;
   logic                 ge;
   logic [RAD_BITS-1:0]  rad_ff, rad_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;

   assign cur   = {up_rem, up_rad[RAD_BITS-1 -: 2]};
   assign trial = {1'b0, up_root, 2'b01};
   assign diff  = cur - trial;
   assign ge    = (cur >= trial);

   // The remainder never exceeds twice the partial root, so it fits its register.
   always_comb begin
      rad_in  = up_rad << 2;
      rem_in  = ge ? diff[REM_BITS-1:0] : cur[REM_BITS-1:0];
      root_in = {up_root[ROOT_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign dn_rad  = rad_ff;
   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;

endmodule

`default_nettype wire

### hdl/cpb_delay.sv
// Fixed-length register line that brings a path into step with a longer one.
`timescale 1ns / 1ps
`default_nettype none

module cpb_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] up_data,
   output logic [WIDTH-1:0] dn_data
);

   generate
      if (DEPTH == 0) begin : g_none
         assign dn_data = up_data;
      end else begin : g_taps
         logic [WIDTH-1:0] tap_ff [DEPTH];

         always_ff @(posedge clock) begin
            tap_ff[0] <= up_data;
            for (int k = 1; k < DEPTH; k++) begin
               tap_ff[k] <= tap_ff[k-1];
            end
         end

         assign dn_data = tap_ff[DEPTH-1];
      end
   endgenerate

endmodule

`default_nettype wire
